/* design/wcf_pkg.sv */
// Shared types, register map, kernel codes and fixed-point constants
// for the window convolution filter. No dependencies.
`default_nettype none

package wcf_pkg;

    localparam int PIX_W   = 8;
    localparam int COORD_W = 10;
    localparam int SIZE_W  = 11;
    localparam int MODE_W  = 3;
    localparam int SUM_W   = 12;

    localparam int CFG_AW = 4;
    localparam int CFG_DW = 32;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_KERNEL_MODE  = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [MODE_W-1:0] RST_KERNEL_MODE = 3'd0;
    localparam logic [SIZE_W-1:0] RST_IMAGE_SIZE  = 11'd512;

    // Kernel selection codes.
    localparam logic [MODE_W-1:0] MODE_BOX       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_GAUSS     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PREWITT_X = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PREWITT_Y = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SOBEL_X   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_SOBEL_Y   = 3'd5;
    localparam logic [MODE_W-1:0] MODE_LAPLACE   = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SHARPEN   = 3'd7;

    // Box weight numerator; the divide by 100000 is a shift by 5 followed
    // by a multiply with the rounded-up reciprocal of 3125 scaled by 2^32.
    localparam logic [13:0] BOX_NUM    = 14'd11111;
    localparam logic [20:0] RECIP_3125 = 21'd1374390;
    // Divide by 3 for magnitudes up to 765: multiply by 683, shift by 11.
    localparam logic [9:0]  RECIP_3    = 10'd683;

    // Window pixels indexed [row][column], row 0 is the top, column 0 the left.
    typedef logic [2:0][2:0][PIX_W-1:0] window_t;

    typedef struct packed {
        logic [COORD_W-1:0] center_row;
        logic [COORD_W-1:0] center_col;
        logic               frame_last;
    } pos_t;

endpackage

`default_nettype wire

/* design/wcf_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`default_nettype none

module wcf_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 1024,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/wcf_window.sv */
// Raster counters, line-store memory and 3x3 window registers.
// Depends on wcf_pkg and wcf_ram.
`default_nettype none

module wcf_window
    import wcf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              restart,
    input  wire logic [SIZE_W-1:0] image_width,
    input  wire logic [SIZE_W-1:0] image_height,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [PIX_W-1:0]  pixel_in,
    output logic                   win_valid,
    input  wire logic              win_ready,
    output window_t                win,
    output pos_t                   pos
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    logic [COL_W-1:0] col_reg, col_next, col_last;
    logic [ROW_W-1:0] row_reg, row_next, row_last;
    logic             accept;
    logic             produce;

    // Stage A: accepted pixel, waiting for its line-store read.
    logic             a_valid_reg, a_valid_next;
    logic             a_prod_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic [COL_W-1:0] a_col_reg;
    pos_t             a_pos_reg;
    logic             a_move;

    // Stage B: full window handed to the kernel datapath.
    logic             b_valid_reg, b_valid_next;
    window_t          b_win_reg;
    pos_t             b_pos_reg;
    logic             b_load;

    logic [2:0][PIX_W-1:0] left_col_reg;
    logic [2:0][PIX_W-1:0] mid_col_reg;
    logic [2*PIX_W-1:0]    ram_rdata;
    logic [PIX_W-1:0]      top_pix, mid_pix;

    // Effective frame size, clamped to 3..MAX.
    always_comb
    begin
        if (image_width < SIZE_W'(3))
            col_last = COL_W'(2);
        else if ({{(32-SIZE_W){1'b0}}, image_width} > 32'(MAX_WIDTH))
            col_last = COL_W'(MAX_WIDTH - 1);
        else
            col_last = COL_W'(image_width - SIZE_W'(1));

        if (image_height < SIZE_W'(3))
            row_last = ROW_W'(2);
        else if ({{(32-SIZE_W){1'b0}}, image_height} > 32'(MAX_HEIGHT))
            row_last = ROW_W'(MAX_HEIGHT - 1);
        else
            row_last = ROW_W'(image_height - SIZE_W'(1));
    end

    assign b_load   = !b_valid_reg || win_ready;
    assign a_move   = a_valid_reg && (!a_prod_reg || b_load);
    assign in_ready = !a_valid_reg || a_move;
    assign accept   = in_valid && in_ready;
    assign produce  = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == col_last)
            begin
                col_next = '0;
                row_next = (row_reg == row_last) ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (a_move)
            a_valid_next = 1'b0;

        b_valid_next = b_valid_reg;
        if (a_move && a_prod_reg)
            b_valid_next = 1'b1;
        else if (win_ready)
            b_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_prod_reg           <= produce;
            a_pix_reg            <= pixel_in;
            a_col_reg            <= col_reg;
            a_pos_reg.center_row <= COORD_W'(row_reg - ROW_W'(1));
            a_pos_reg.center_col <= COORD_W'(col_reg - COL_W'(1));
            a_pos_reg.frame_last <= (row_reg == row_last) && (col_reg == col_last);
        end
        if (a_move)
        begin
            left_col_reg <= mid_col_reg;
            mid_col_reg  <= {a_pix_reg, mid_pix, top_pix};
            if (a_prod_reg)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    b_win_reg[r][0] <= left_col_reg[r];
                    b_win_reg[r][1] <= mid_col_reg[r];
                end
                b_win_reg[0][2] <= top_pix;
                b_win_reg[1][2] <= mid_pix;
                b_win_reg[2][2] <= a_pix_reg;
                b_pos_reg       <= a_pos_reg;
            end
        end
    end

    // Each entry holds {upper line, middle line} for one column. The read
    // is issued on acceptance and the entry is rewritten when the pixel
    // leaves stage A; the same column is not read again for at least three
    // transfers, so no forwarding is needed.
    wcf_ram #(
        .DATA_W (2*PIX_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (a_move),
        .waddr (a_col_reg),
        .wdata ({mid_pix, a_pix_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (ram_rdata)
    );

    assign top_pix = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid_pix = ram_rdata[PIX_W-1:0];

    assign win_valid = b_valid_reg;
    assign win       = b_win_reg;
    assign pos       = b_pos_reg;

endmodule

`default_nettype wire

/* design/wcf_kernel.sv */
// Three-stage kernel datapath: window sums, first multiply, final
// multiply and result register. Depends on wcf_pkg.
`default_nettype none

module wcf_kernel
    import wcf_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [MODE_W-1:0] kernel_mode,
    input  wire logic              win_valid,
    output logic                   win_ready,
    input  wire window_t           win,
    input  wire pos_t              pos,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [PIX_W-1:0]       pixel_out,
    output pos_t                   out_pos
);

    logic signed [12:0] px [3][3];
    logic signed [12:0] sum_all, gauss_sum, prewitt_x, prewitt_y;
    logic signed [12:0] sobel_x, sobel_y, lap_val, sharp_val, sel_val;
    logic [11:0]        sel_mag;
    logic [9:0]         pre_next;

    logic              k1_valid_reg, k1_valid_next;
    logic [MODE_W-1:0] k1_mode_reg;
    logic [SUM_W-1:0]  k1_sum_reg;
    logic [9:0]        k1_pre_reg;
    pos_t              k1_pos_reg;

    logic              k2_valid_reg, k2_valid_next;
    logic [MODE_W-1:0] k2_mode_reg;
    logic [19:0]       k2_quot_reg;
    logic [PIX_W-1:0]  k2_pre_reg;
    pos_t              k2_pos_reg;

    logic              k3_valid_reg, k3_valid_next;
    logic [PIX_W-1:0]  k3_pix_reg;
    pos_t              k3_pos_reg;

    logic              k1_move, k2_move, k3_load, k2_load;
    logic [25:0]       box_prod;
    logic [19:0]       third_prod;
    logic [40:0]       final_prod;
    logic              k1_prewitt;

    assign k3_load   = !k3_valid_reg || out_ready;
    assign k2_move   = k2_valid_reg && k3_load;
    assign k2_load   = !k2_valid_reg || k2_move;
    assign k1_move   = k1_valid_reg && k2_load;
    assign win_ready = !k1_valid_reg || k1_move;

    // Stage 1: all kernel sums in parallel, then the selected one reduced.
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                px[r][c] = $signed({5'b0, win[r][c]});
            end
        end
        sum_all = px[0][0] + px[0][1] + px[0][2] + px[1][0] + px[1][1] + px[1][2]
                + px[2][0] + px[2][1] + px[2][2];
        gauss_sum = px[0][0] + (px[0][1] <<< 1) + px[0][2]
                  + (px[1][0] <<< 1) + (px[1][1] <<< 2) + (px[1][2] <<< 1)
                  + px[2][0] + (px[2][1] <<< 1) + px[2][2];
        prewitt_x = (px[0][2] + px[1][2] + px[2][2]) - (px[0][0] + px[1][0] + px[2][0]);
        prewitt_y = (px[2][0] + px[2][1] + px[2][2]) - (px[0][0] + px[0][1] + px[0][2]);
        sobel_x = (px[0][2] - px[0][0]) + ((px[1][2] - px[1][0]) <<< 1)
                + (px[2][2] - px[2][0]);
        sobel_y = (px[2][0] - px[0][0]) + ((px[2][1] - px[0][1]) <<< 1)
                + (px[2][2] - px[0][2]);
        lap_val   = (px[1][1] <<< 3) + px[1][1] - sum_all;
        sharp_val = (px[1][1] <<< 3) + (px[1][1] <<< 1) - sum_all;

        case (kernel_mode)
            MODE_GAUSS:     sel_val = gauss_sum;
            MODE_PREWITT_X: sel_val = prewitt_x;
            MODE_PREWITT_Y: sel_val = prewitt_y;
            MODE_SOBEL_X:   sel_val = sobel_x;
            MODE_SOBEL_Y:   sel_val = sobel_y;
            MODE_LAPLACE:   sel_val = lap_val;
            default:        sel_val = sharp_val;
        endcase
        sel_mag = sel_val[12] ? 12'(-sel_val) : 12'(sel_val);

        case (kernel_mode)
            MODE_GAUSS:     pre_next = {2'b0, gauss_sum[11:4]};
            MODE_PREWITT_X: pre_next = sel_mag[9:0];
            MODE_PREWITT_Y: pre_next = sel_mag[9:0];
            MODE_SOBEL_X:   pre_next = {2'b0, sel_mag[9:2]};
            MODE_SOBEL_Y:   pre_next = {2'b0, sel_mag[9:2]};
            MODE_LAPLACE:   pre_next = {2'b0, sel_mag[10:3]};
            MODE_SHARPEN:
            begin
                if (sel_val[12])
                    pre_next = '0;
                else if (sel_val > 13'sd255)
                    pre_next = 10'd255;
                else
                    pre_next = {2'b0, sel_val[7:0]};
            end
            default:        pre_next = '0;
        endcase
    end

    // Stage 2 multiplies: box numerator, and the divide by 3 for Prewitt.
    assign box_prod   = {14'b0, k1_sum_reg} * {12'b0, BOX_NUM};
    assign third_prod = {10'b0, k1_pre_reg} * {10'b0, RECIP_3};
    assign k1_prewitt = (k1_mode_reg == MODE_PREWITT_X) || (k1_mode_reg == MODE_PREWITT_Y);

    // Stage 3 multiply: remaining divide by 3125 of the box path.
    assign final_prod = {21'b0, k2_quot_reg} * {20'b0, RECIP_3125};

    always_comb
    begin
        k1_valid_next = k1_valid_reg;
        if (win_valid && win_ready)
            k1_valid_next = 1'b1;
        else if (k1_move)
            k1_valid_next = 1'b0;

        k2_valid_next = k2_valid_reg;
        if (k1_move)
            k2_valid_next = 1'b1;
        else if (k2_move)
            k2_valid_next = 1'b0;

        k3_valid_next = k3_valid_reg;
        if (k2_move)
            k3_valid_next = 1'b1;
        else if (out_ready)
            k3_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k1_valid_reg <= 1'b0;
            k2_valid_reg <= 1'b0;
            k3_valid_reg <= 1'b0;
        end
        else
        begin
            k1_valid_reg <= k1_valid_next;
            k2_valid_reg <= k2_valid_next;
            k3_valid_reg <= k3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (win_valid && win_ready)
        begin
            k1_mode_reg <= kernel_mode;
            k1_sum_reg  <= SUM_W'(sum_all);
            k1_pre_reg  <= pre_next;
            k1_pos_reg  <= pos;
        end
        if (k1_move)
        begin
            k2_mode_reg <= k1_mode_reg;
            k2_quot_reg <= box_prod[24:5];
            k2_pre_reg  <= k1_prewitt ? third_prod[18:11] : k1_pre_reg[7:0];
            k2_pos_reg  <= k1_pos_reg;
        end
        if (k2_move)
        begin
            k3_pix_reg <= (k2_mode_reg == MODE_BOX) ? final_prod[39:32] : k2_pre_reg;
            k3_pos_reg <= k2_pos_reg;
        end
    end

    assign out_valid = k3_valid_reg;
    assign pixel_out = k3_pix_reg;
    assign out_pos   = k3_pos_reg;

endmodule

`default_nettype wire

/* design/window_convolution_filter_unit.sv */
// Top level of the 3x3 window convolution filter: configuration registers,
// line-store window front end and kernel datapath.
// Depends on wcf_pkg, wcf_window, wcf_kernel and wcf_ram.
//
//   Channel   Direction  Handshake            Payload
//   --------  ---------  -------------------  -------------------------------------
//   pixel     in         in_valid/in_ready    pixel_in
//   result    out        out_valid/out_ready  pixel_out, center_row, center_col,
//                                             frame_last
//   config    in/out     APB (pready = 1)     paddr, pwdata, prdata
//
// The filter accepts one pixel transfer per clock cycle, back to back, while
// out_ready back-pressure has not filled the pipeline. A pixel passes five
// registers: line-store read, window, and three arithmetic stages. The
// accepting edge loads the first; out_valid is the valid bit of the last.
// Every stage holds its own valid bit, so a stalled result stops the input
// only once all stages in front of it are full. Reset clears the counters,
// valid bits and configuration registers; the line store is not cleared,
// since no result uses an entry before the current frame has written it.
`default_nettype none

module window_convolution_filter_unit
    import wcf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [CFG_AW-1:0]  paddr,
    input  wire logic [CFG_DW-1:0]  pwdata,
    output logic      [CFG_DW-1:0]  prdata,
    output logic                    pready,
    // Pixel input
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [PIX_W-1:0]   pixel_in,
    // Filtered result
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [PIX_W-1:0]   pixel_out,
    output logic      [COORD_W-1:0] center_row,
    output logic      [COORD_W-1:0] center_col,
    output logic                    frame_last
);

    logic [MODE_W-1:0] kernel_mode_reg;
    logic [SIZE_W-1:0] image_width_reg;
    logic [SIZE_W-1:0] image_height_reg;
    logic              cfg_write;
    logic              restart;
    logic [1:0]        reg_index;

    logic              win_valid;
    logic              win_ready;
    window_t           win;
    pos_t              win_pos;
    pos_t              out_pos;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = paddr[CFG_AW-1:2];

    // A size write restarts the frame at row 0, column 0; a mode write applies to
    // the next window the kernel takes. Writes to other addresses are dropped.
    assign restart = cfg_write &&
                     ((reg_index == REG_IMAGE_WIDTH) || (reg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_mode_reg  <= RST_KERNEL_MODE;
            image_width_reg  <= RST_IMAGE_SIZE;
            image_height_reg <= RST_IMAGE_SIZE;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_KERNEL_MODE:  kernel_mode_reg  <= pwdata[MODE_W-1:0];
                REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: image_height_reg <= pwdata[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_KERNEL_MODE:  prdata = {{(CFG_DW-MODE_W){1'b0}}, kernel_mode_reg};
            REG_IMAGE_WIDTH:  prdata = {{(CFG_DW-SIZE_W){1'b0}}, image_width_reg};
            REG_IMAGE_HEIGHT: prdata = {{(CFG_DW-SIZE_W){1'b0}}, image_height_reg};
            default:          prdata = '0;
        endcase
    end

    // Raster counters, line store and window registers.
    wcf_window #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .image_width  (image_width_reg),
        .image_height (image_height_reg),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .pixel_in     (pixel_in),
        .win_valid    (win_valid),
        .win_ready    (win_ready),
        .win          (win),
        .pos          (win_pos)
    );

    // Kernel arithmetic; its last stage is the output register.
    wcf_kernel u_kernel (
        .clk         (clk),
        .rst_n       (rst_n),
        .kernel_mode (kernel_mode_reg),
        .win_valid   (win_valid),
        .win_ready   (win_ready),
        .win         (win),
        .pos         (win_pos),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_out   (pixel_out),
        .out_pos     (out_pos)
    );

    assign center_row = out_pos.center_row;
    assign center_col = out_pos.center_col;
    assign frame_last = out_pos.frame_last;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
// Self-checking testbench for window_convolution_filter_unit: raster pixel
// frames in, filtered window centers out, all checked against an in-bench model.
// Depends on wcf_pkg and the filter RTL only.

module tb_top
    import wcf_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 1;
    localparam int RESET_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 80;
    localparam int SMALL_PHASES   = 16;
    localparam int WIDE_WIDTH     = 160;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_LIMIT    = 100000;
    localparam int RUN_LIMIT_NS   = 1000000;

    // The address decoder has a fourth slot with no register behind it.
    localparam logic [1:0] REG_SPARE = 2'd3;

    // One predicted result: the filtered value plus its window position.
    typedef struct packed {
        logic [PIX_W-1:0] value;
        pos_t             pos;
    } filt_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [CFG_AW-1:0]  paddr = '0;
    logic [CFG_DW-1:0]  pwdata = '0;
    logic [CFG_DW-1:0]  prdata;
    logic               pready;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [PIX_W-1:0]   pixel_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [PIX_W-1:0]   pixel_out;
    logic [COORD_W-1:0] center_row;
    logic [COORD_W-1:0] center_col;
    logic               frame_last;

    window_convolution_filter_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pixel_in   (pixel_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .pixel_out  (pixel_out),
        .center_row (center_row),
        .center_col (center_col),
        .frame_last (frame_last)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Pixels waiting to be offered, and filtered results waiting to come out.
    logic [PIX_W-1:0] pixel_queue [$];
    filt_result_t     predicted_pixels [$];

    // Idle and stall rates in percent, set per phase by the stimulus.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // The stimulus asks for a long result hold-off by bumping the request
    // count; the receiver process counts the hold-off down on its own.
    int holdoff_requests = 0;
    int holdoffs_begun   = 0;
    int holdoff_left     = 0;

    logic pixel_taken = 1'b0;

    int fail_count      = 0;
    int pixels_accepted = 0;
    int results_seen    = 0;
    int input_stalls    = 0;
    int settings_used   = 0;

    // Model state: register shadows, the two line stores, the two window
    // columns held from earlier pixels, and the raster position.
    logic [MODE_W-1:0] cfg_mode   = RST_KERNEL_MODE;
    logic [SIZE_W-1:0] cfg_width  = RST_IMAGE_SIZE;
    logic [SIZE_W-1:0] cfg_height = RST_IMAGE_SIZE;
    logic [PIX_W-1:0]  upper_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]  middle_line [DEF_MAX_WIDTH];
    logic [PIX_W-1:0]  win_cols [6];
    int unsigned       row_idx = 0;
    int unsigned       col_idx = 0;

    // Frame sizes are used clamped to 3..max, whatever the register holds.
    function automatic int unsigned size_limit(input logic [SIZE_W-1:0] v, input int maxv);
        if (v < 3)
            return 3;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Advance the model by one accepted pixel. When the window center lands
    // on an interior position, the filtered value is queued as a prediction.
    task automatic slide_window(input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      c;
        int unsigned      r;
        int               px [3][3];
        int               total;
        int               v;
        int               res;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        filt_result_t     item;
        w = size_limit(cfg_width, DEF_MAX_WIDTH);
        h = size_limit(cfg_height, DEF_MAX_HEIGHT);
        if (col_idx >= w)
            col_idx = 0;
        if (row_idx >= h)
            row_idx = 0;
        c = col_idx;
        r = row_idx;
        top = upper_line[c];
        mid = middle_line[c];
        upper_line[c] = mid;
        middle_line[c] = pix;

        if (r >= 2 && c >= 2)
        begin
            for (int k = 0; k < 3; k++)
            begin
                px[k][0] = win_cols[k];
                px[k][1] = win_cols[3 + k];
            end
            px[0][2] = top;
            px[1][2] = mid;
            px[2][2] = pix;
            total = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    total += px[i][j];
            case (cfg_mode)
                MODE_BOX:
                    // Weight 0.11111 applied as an exact fraction, truncated.
                    res = total * 11111 / 100000;
                MODE_GAUSS:
                begin
                    v = px[0][0] + 2 * px[0][1] + px[0][2]
                      + 2 * px[1][0] + 4 * px[1][1] + 2 * px[1][2]
                      + px[2][0] + 2 * px[2][1] + px[2][2];
                    res = v / 16;
                end
                MODE_PREWITT_X:
                begin
                    v = (px[0][2] + px[1][2] + px[2][2]) - (px[0][0] + px[1][0] + px[2][0]);
                    res = magnitude(v) / 3;
                end
                MODE_PREWITT_Y:
                begin
                    v = (px[2][0] + px[2][1] + px[2][2]) - (px[0][0] + px[0][1] + px[0][2]);
                    res = magnitude(v) / 3;
                end
                MODE_SOBEL_X:
                begin
                    v = (px[0][2] - px[0][0]) + 2 * (px[1][2] - px[1][0])
                      + (px[2][2] - px[2][0]);
                    res = magnitude(v) / 4;
                end
                MODE_SOBEL_Y:
                begin
                    v = (px[2][0] - px[0][0]) + 2 * (px[2][1] - px[0][1])
                      + (px[2][2] - px[0][2]);
                    res = magnitude(v) / 4;
                end
                MODE_LAPLACE:
                begin
                    v = 9 * px[1][1] - total;
                    res = magnitude(v) / 8;
                end
                default:
                begin
                    // Sharpening saturates instead of taking a magnitude.
                    v = 10 * px[1][1] - total;
                    res = (v < 0) ? 0 : ((v > 255) ? 255 : v);
                end
            endcase
            item.value = PIX_W'(res);
            item.pos.center_row = COORD_W'(r - 1);
            item.pos.center_col = COORD_W'(c - 1);
            item.pos.frame_last = (r == h - 1) && (c == w - 1);
            predicted_pixels.push_back(item);
        end

        win_cols[0] = win_cols[3];
        win_cols[1] = win_cols[4];
        win_cols[2] = win_cols[5];
        win_cols[3] = top;
        win_cols[4] = mid;
        win_cols[5] = pix;

        c++;
        if (c >= w)
        begin
            c = 0;
            r++;
            if (r >= h)
                r = 0;
        end
        col_idx = c;
        row_idx = r;
    endtask

    // Pixel driver. A new transfer is offered only once the previous one was
    // taken (or nothing was offered), so valid and data stay put while the
    // filter holds in_ready low.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            pixel_in <= '0;
        end
        else if (!in_valid || pixel_taken)
        begin
            if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                pixel_in <= pixel_queue.pop_front();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result receiver. A pending hold-off keeps out_ready low for a long,
    // fixed stretch so that the pipeline fills and pushes back on the input;
    // otherwise ready follows the stall rate of the current phase.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (holdoff_left != 0)
        begin
            out_ready <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
        else if (holdoffs_begun < holdoff_requests)
        begin
            out_ready <= 1'b0;
            holdoff_left <= HOLDOFF_CYCLES;
            holdoffs_begun <= holdoffs_begun + 1;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor. Every accepted pixel transfer steps the model; every accepted
    // result transfer is checked against the oldest prediction.
    always @(posedge clk)
    begin : transfer_monitor
        filt_result_t want;
        if (!rst_n)
        begin
            pixel_taken <= 1'b0;
        end
        else
        begin
            pixel_taken <= in_valid && in_ready;
            if (in_valid && !in_ready)
                input_stalls++;
            if (in_valid && in_ready)
            begin
                slide_window(pixel_in);
                pixels_accepted++;
            end
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (predicted_pixels.size() == 0)
                begin
                    $display("%0t ns: unexpected result: pixel %0d row %0d col %0d last %0b",
                             $time, pixel_out, center_row, center_col, frame_last);
                    fail_count++;
                end
                else
                begin
                    want = predicted_pixels.pop_front();
                    if (pixel_out !== want.value || center_row !== want.pos.center_row ||
                        center_col !== want.pos.center_col ||
                        frame_last !== want.pos.frame_last)
                    begin
                        $display({"%0t ns: mismatch: expected pixel %0d row %0d col %0d ",
                                  "last %0b, got pixel %0d row %0d col %0d last %0b"},
                                 $time, want.value, want.pos.center_row,
                                 want.pos.center_col, want.pos.frame_last,
                                 pixel_out, center_row, center_col, frame_last);
                        fail_count++;
                    end
                end
            end
        end
    end

    // One APB transfer: setup phase, then access phase; pready is tied high,
    // so the access completes at the first rising edge of the access phase.
    task automatic apb_xfer(input logic write, input logic [1:0] idx,
                            input logic [CFG_DW-1:0] wdata,
                            output logic [CFG_DW-1:0] rdata);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Register write plus the matching update of the model. A size write
    // restarts the frame; the spare address has nothing behind it.
    task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
        logic [CFG_DW-1:0] rd_discard;
        apb_xfer(1'b1, idx, value, rd_discard);
        case (idx)
            REG_KERNEL_MODE:
                cfg_mode = value[MODE_W-1:0];
            REG_IMAGE_WIDTH:
            begin
                cfg_width = value[SIZE_W-1:0];
                row_idx = 0;
                col_idx = 0;
            end
            REG_IMAGE_HEIGHT:
            begin
                cfg_height = value[SIZE_W-1:0];
                row_idx = 0;
                col_idx = 0;
            end
            default: ;
        endcase
    endtask

    task automatic check_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] want);
        logic [CFG_DW-1:0] got;
        apb_xfer(1'b0, idx, '0, got);
        if (got !== want)
        begin
            $display("%0t ns: register %0d read back 0x%0h, expected 0x%0h",
                     $time, idx, got, want);
            fail_count++;
        end
    endtask

    task automatic check_all_regs();
        check_reg(REG_KERNEL_MODE, CFG_DW'(cfg_mode));
        check_reg(REG_IMAGE_WIDTH, CFG_DW'(cfg_width));
        check_reg(REG_IMAGE_HEIGHT, CFG_DW'(cfg_height));
    endtask

    // Program a kernel and frame size. Now and then the unused upper data
    // bits carry noise, which the registers must drop.
    task automatic configure(input logic [MODE_W-1:0] mode, input int width, input int height);
        logic [CFG_DW-1:0] junk;
        junk = ($urandom_range(3) == 0) ? $urandom() : '0;
        write_reg(REG_KERNEL_MODE, {junk[CFG_DW-1:MODE_W], mode});
        write_reg(REG_IMAGE_WIDTH, {junk[CFG_DW-1:SIZE_W], SIZE_W'(width)});
        write_reg(REG_IMAGE_HEIGHT, {junk[CFG_DW-1:SIZE_W], SIZE_W'(height)});
        settings_used++;
        check_all_regs();
    endtask

    // Queue raster pixels with one of several textures: plain noise, hard
    // black and white, a noisy ramp, or a flat field with rare spikes.
    task automatic queue_pixels(input int count, input int w);
        int               style;
        int               base;
        logic [PIX_W-1:0] p;
        style = $urandom_range(3);
        base = $urandom_range(255);
        for (int k = 0; k < count; k++)
        begin
            case (style)
                0: p = PIX_W'($urandom_range(255));
                1: p = $urandom_range(1) ? 8'hFF : 8'h00;
                2: p = PIX_W'(base + (k % w) * 23 + (k / w) * 41 + $urandom_range(7));
                default:
                begin
                    if ($urandom_range(9) == 0)
                        p = $urandom_range(1) ? 8'hFF : 8'h00;
                    else
                        p = PIX_W'(base);
                end
            endcase
            pixel_queue.push_back(p);
        end
    endtask

    // A 3x3 frame with one value in the center and another all around it.
    task automatic queue_3x3(input logic [PIX_W-1:0] center_pix, input logic [PIX_W-1:0] ring);
        for (int k = 0; k < 9; k++)
            pixel_queue.push_back((k == 4) ? center_pix : ring);
    endtask

    // Wait until every queued pixel was transferred and every predicted
    // result arrived, then give the pipeline time to finish any pixel that
    // produces no result before the next register write.
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((pixel_queue.size() != 0 || in_valid || predicted_pixels.size() != 0) &&
               guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= DRAIN_LIMIT)
        begin
            $display("%0t ns: transfers still pending after %0d cycles", $time, DRAIN_LIMIT);
            fail_count++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                idle_plan;
        int                width_val;
        int                height_val;
        int                w_eff;
        int                h_eff;
        int                frame_px;
        int                nframes;
        logic [MODE_W-1:0] mode_val;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset values first, then a few hand-made frames: a saturated box
        // average and both clamp limits of the sharpening kernel.
        check_all_regs();
        configure(MODE_BOX, 3, 3);
        queue_3x3(8'hFF, 8'hFF);
        wait_idle();
        write_reg(REG_KERNEL_MODE, CFG_DW'(MODE_SHARPEN));
        queue_3x3(8'hFF, 8'h00);
        queue_3x3(8'h00, 8'hFF);
        wait_idle();
        // A write to the unmapped slot must leave every register untouched.
        write_reg(REG_SPARE, $urandom());
        check_all_regs();

        // Random phases: all kernels, small frames, occasional size values
        // below the legal range, and four idle plans in turn.
        for (int phase = 0; phase < SMALL_PHASES; phase++)
        begin
            idle_plan = phase / 4;
            case (idle_plan)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 49;
                end
                default:
                begin
                    send_idle_pct = 36;
                    recv_stall_pct = 36;
                end
            endcase
            mode_val = MODE_W'(phase % 8);
            width_val = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 12);
            height_val = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 8);
            configure(mode_val, width_val, height_val);
            w_eff = size_limit(SIZE_W'(width_val), DEF_MAX_WIDTH);
            h_eff = size_limit(SIZE_W'(height_val), DEF_MAX_HEIGHT);
            frame_px = w_eff * h_eff;
            nframes = (PHASE_ITEMS / frame_px == 0) ? 1 : PHASE_ITEMS / frame_px;
            for (int f = 0; f < nframes; f++)
                queue_pixels(frame_px, w_eff);
            // About half the phases, at random, end in a cut-off frame that the next
            // size write abandons.
            if ($urandom_range(1))
                queue_pixels($urandom_range(1, frame_px - 1), w_eff);
            // Back-pressure test: results are held off while pixels keep
            // coming, so the filter must fill up and stall its input.
            if (phase == 1)
                holdoff_requests++;
            wait_idle();
        end

        // Large sizes: one full frame on a wide line, a tall narrow strip
        // with the height above range, and a width above range that only
        // ever sees its first row.
        send_idle_pct = 36;
        recv_stall_pct = 36;
        configure(MODE_W'($urandom_range(7)), WIDE_WIDTH, 3);
        queue_pixels(WIDE_WIDTH * 3, WIDE_WIDTH);
        wait_idle();
        configure(MODE_W'($urandom_range(7)), 3, 2047);
        queue_pixels(90, 3);
        wait_idle();
        configure(MODE_W'($urandom_range(7)), DEF_MAX_WIDTH + 1, 3);
        queue_pixels(40, DEF_MAX_WIDTH);
        wait_idle();

        if (predicted_pixels.size() != 0)
        begin
            $display("%0t ns: %0d predicted results never arrived",
                     $time, predicted_pixels.size());
            fail_count += predicted_pixels.size();
        end
        $display("Covered %0d pixel transfers and %0d result transfers over %0d settings",
                 pixels_accepted, results_seen, settings_used);
        $display("of all eight kernels; input held back in %0d cycles, %0d errors seen.",
                 input_stalls, fail_count);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

/* files.f */
design/wcf_pkg.sv
design/wcf_ram.sv
design/wcf_window.sv
design/wcf_kernel.sv
design/window_convolution_filter_unit.sv
tb/tb_top.sv
